/* rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit heap allocator
// Field widths, operation and status codes, controller states and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Default sizing of the arena.
  localparam int DEF_ARENA_GRANULES = 4096;
  localparam int DEF_GRANULE_BYTES  = 16;

  // Fixed field widths of the request and result ports.
  localparam int FUNC_W   = 2;
  localparam int BYTES_W  = 16;
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 2;

  // Configuration register and bus.
  localparam int CFG_W     = 13;
  localparam int LIMIT_MAX = (1 << CFG_W) - 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [CFG_W-1:0] ARENA_LIMIT_RST = CFG_W'(4096);
  localparam logic [PADDR_W-3:0] REG_ARENA_LIMIT = 1'b0;

  // Mask and position of the unused mark in a header word.
  localparam int FREE_MARK_MASK = 1;
  localparam int UNUSED_BIT     = 0;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_REALLOC = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 2'd0,
    RS_NO_SPACE = 2'd1,
    RS_ZERO     = 2'd2
  } res_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_MUL,
    S_DIV_FIX,
    S_OLD_RD,
    S_OLD_GET,
    S_WALK_INIT,
    S_WALK,
    S_APPEND,
    S_FREE_DO,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_mul;
    logic div_fix;
    logic old_rd;
    logic old_get;
    logic walk_init;
    logic walk_adv;
    logic walk_take;
    logic append;
    logic free_do;
    logic set_res_old;
    logic set_st_zero;
    logic set_st_nospace;
    logic set_cp;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              bytes_zero;
    logic              addr_zero;
    logic              old_fits;
    logic              walk_any;
    logic              walk_hit;
    logic              walk_more;
    logic              append_ok;
  } dp_sts_t;

  // The break can never pass the smaller of the arena and the register range.
  function automatic int f_limit_cap(input int arena);
    return (arena < LIMIT_MAX) ? arena : LIMIT_MAX;
  endfunction

endpackage

`default_nettype wire

/* rtl/ffa_dp.sv */
// ----------------------------------------------------------------------------
// ffa_dp: allocator datapath
// Holds the header memory, the break pointer, the walk cursor, the byte to
// granule converter and the result registers. It acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp #(
  parameter int ARENA_GRANULES = 4096,
  parameter int GRANULE_BYTES  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ffa_pkg::FUNC_W-1:0]     in_func,
  input  logic [ffa_pkg::BYTES_W-1:0]    in_req_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]     in_block_addr,
  input  logic [ffa_pkg::CFG_W-1:0]      arena_limit,
  input  ffa_pkg::dp_cmd_t               cmd,
  output ffa_pkg::dp_sts_t               sts,
  output logic [ffa_pkg::ADDR_W-1:0]     result_addr,
  output logic [ffa_pkg::STATUS_W-1:0]   status,
  output logic [ffa_pkg::ADDR_W-1:0]     copy_granules
);
  import ffa_pkg::*;

  localparam int LIMIT_CAP = f_limit_cap(ARENA_GRANULES);
  localparam int MEM_DEPTH = LIMIT_CAP;
  localparam int IW        = $clog2(MEM_DEPTH);
  localparam int BW        = $clog2(LIMIT_CAP + 1);
  localparam int SW        = $clog2(LIMIT_CAP - 1);
  localparam int HW        = SW + 1;
  localparam int NW        = BYTES_W;
  localparam int CW        = ((NW > BW) ? NW : BW) + 1;
  localparam int XW        = BYTES_W + 1;
  localparam int RK        = XW;
  localparam int RECIP     = (1 << RK) / GRANULE_BYTES;
  localparam int MW        = $clog2(RECIP + 1);
  localparam int PW        = XW + MW;

  logic [HW-1:0]       mem [MEM_DEPTH];

  logic [FUNC_W-1:0]   func_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [PW-1:0]       p_r;
  logic [NW-1:0]       n_r;
  logic [SW-1:0]       osz_r;
  logic [BW-1:0]       cur_r, cur_nxt;
  logic [BW-1:0]       brk_r, brk_nxt;
  logic [HW-1:0]       rd_q;
  logic [ADDR_W-1:0]   res_r;
  logic [STATUS_W-1:0] st_r;
  logic [ADDR_W-1:0]   cp_r;

  logic [XW-1:0]       x, q0, qg, rem, q;
  logic [SW-1:0]       rd_size;
  logic                rd_unused;
  logic [CW-1:0]       walk_nxt, new_brk;
  logic [ADDR_W-1:0]   hi;
  logic [BW-1:0]       limit_eff;
  logic                free_last;
  logic [IW-1:0]       rd_addr, wr_addr;
  logic [HW-1:0]       wr_data;
  logic                wr_en;

  // Bytes to granules: multiply by a scaled reciprocal, then one correction.
  assign x   = XW'(bytes_r) + XW'(GRANULE_BYTES - 1);
  assign q0  = XW'(p_r >> RK);
  assign qg  = XW'(q0 * XW'(GRANULE_BYTES));
  assign rem = x - qg;
  assign q   = (rem >= XW'(GRANULE_BYTES)) ? q0 + XW'(1) : q0;

  assign rd_size   = rd_q[HW-1:1];
  assign rd_unused = rd_q[UNUSED_BIT];
  assign walk_nxt  = CW'(cur_r) + CW'(1) + CW'(rd_size);
  assign new_brk   = CW'(brk_r) + CW'(1) + CW'(n_r);
  assign hi        = addr_r - ADDR_W'(1);
  assign limit_eff = (arena_limit < CFG_W'(LIMIT_CAP)) ? BW'(arena_limit) : BW'(LIMIT_CAP);
  assign free_last = (CW'(addr_r) + CW'(osz_r)) == CW'(brk_r);

  always_comb begin
    sts.func       = func_r;
    sts.bytes_zero = (bytes_r == '0);
    sts.addr_zero  = (addr_r == '0);
    sts.old_fits   = CW'(rd_size) >= CW'(n_r);
    sts.walk_any   = CW'(1) < CW'(brk_r);
    sts.walk_hit   = rd_unused && (CW'(rd_size) >= CW'(n_r));
    sts.walk_more  = walk_nxt < CW'(brk_r);
    sts.append_ok  = new_brk <= CW'(limit_eff);
  end

  // Header memory port selection.
  always_comb begin
    priority if (cmd.old_rd) begin
      rd_addr = IW'(hi);
    end else if (cmd.walk_init) begin
      rd_addr = IW'(1);
    end else if (cmd.walk_adv) begin
      rd_addr = IW'(walk_nxt);
    end else begin
      rd_addr = IW'(cur_r);
    end

    wr_en   = 1'b0;
    wr_addr = IW'(cur_r);
    wr_data = {rd_size, 1'b0};
    priority if (cmd.walk_take) begin
      wr_en = 1'b1;
    end else if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = IW'(brk_r);
      wr_data = {SW'(n_r), 1'b0};
    end else if (cmd.free_do && !free_last) begin
      wr_en   = 1'b1;
      wr_addr = IW'(hi);
      wr_data = {osz_r, 1'b1};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Walk cursor and break pointer.
  always_comb begin
    cur_nxt = cur_r;
    if (cmd.walk_init) begin
      cur_nxt = BW'(1);
    end else if (cmd.walk_adv) begin
      cur_nxt = BW'(walk_nxt);
    end
    brk_nxt = brk_r;
    if (cmd.append) begin
      brk_nxt = BW'(new_brk);
    end else if (cmd.free_do && free_last) begin
      brk_nxt = BW'(hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r <= BW'(1);
    end else begin
      brk_r <= brk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.load) begin
      func_r  <= in_func;
      bytes_r <= in_req_bytes;
      addr_r  <= in_block_addr;
    end
    if (cmd.div_mul) begin
      p_r <= PW'(x) * PW'(RECIP);
    end
    if (cmd.div_fix) begin
      n_r <= NW'(q);
    end
    if (cmd.old_get) begin
      osz_r <= rd_size;
    end

    if (cmd.load) begin
      res_r <= '0;
      st_r  <= RS_OK;
      cp_r  <= '0;
    end else begin
      if (cmd.walk_take) begin
        res_r <= ADDR_W'(CW'(cur_r) + CW'(1));
      end else if (cmd.append) begin
        res_r <= ADDR_W'(CW'(brk_r) + CW'(1));
      end else if (cmd.set_res_old) begin
        res_r <= addr_r;
      end
      if (cmd.set_st_zero) begin
        st_r <= RS_ZERO;
      end else if (cmd.set_st_nospace) begin
        st_r <= RS_NO_SPACE;
      end
      if (cmd.set_cp) begin
        cp_r <= ADDR_W'(osz_r);
      end
    end
  end

  assign result_addr   = res_r;
  assign status        = st_r;
  assign copy_granules = cp_r;

endmodule

`default_nettype wire

/* rtl/ffa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator controller
// Sequences one request through decode, size conversion, header walk,
// append and free steps, and raises the result strobe at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ffa_pkg::dp_sts_t sts,
  output ffa_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             done
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;
  logic   realloc_move;
  logic   alloc_like;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A reallocation of a live block to a nonzero size may move it.
  assign realloc_move = (sts.func == FN_REALLOC) && !sts.addr_zero && !sts.bytes_zero;
  assign alloc_like   = (sts.func == FN_ALLOC) || ((sts.func == FN_REALLOC) && sts.addr_zero);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = (state_r != S_IDLE);
    done      = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (alloc_like) begin
          if (sts.bytes_zero) begin
            cmd.set_st_zero = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            state_nxt = S_DIV_MUL;
          end
        end else if (sts.func == FN_FREE) begin
          state_nxt = sts.addr_zero ? S_DONE : S_OLD_RD;
        end else if (sts.func == FN_REALLOC) begin
          if (sts.bytes_zero) begin
            cmd.set_st_zero = 1'b1;
            state_nxt       = S_OLD_RD;
          end else begin
            state_nxt = S_DIV_MUL;
          end
        end else begin
          cmd.set_st_zero = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = realloc_move ? S_OLD_RD : S_WALK_INIT;
      end
      S_OLD_RD: begin
        cmd.old_rd = 1'b1;
        state_nxt  = S_OLD_GET;
      end
      S_OLD_GET: begin
        cmd.old_get = 1'b1;
        if (!realloc_move) begin
          state_nxt = S_FREE_DO;
        end else if (sts.old_fits) begin
          cmd.set_res_old = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_WALK_INIT;
        end
      end
      S_WALK_INIT: begin
        if (sts.walk_any) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_WALK: begin
        priority if (sts.walk_hit) begin
          cmd.walk_take = 1'b1;
          cmd.set_cp    = realloc_move;
          state_nxt     = realloc_move ? S_FREE_DO : S_DONE;
        end else if (sts.walk_more) begin
          cmd.walk_adv = 1'b1;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.append_ok) begin
          cmd.append = 1'b1;
          cmd.set_cp = realloc_move;
          state_nxt  = realloc_move ? S_FREE_DO : S_DONE;
        end else begin
          cmd.set_st_nospace = 1'b1;
          state_nxt          = S_DONE;
        end
      end
      S_FREE_DO: begin
        cmd.free_do = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over an arena of granules
// Allocate, free and reallocate requests against a header store that grows
// from a break pointer, with an APB-style register for the arena limit.
// ----------------------------------------------------------------------------
// How to use this block:
// A request is issued by holding start high with in_func, in_req_bytes and
// in_block_addr valid; it is taken at the first rising edge where busy is low.
// The block handles one request at a time and keeps busy high until the
// result has been presented. The result appears on out_result_addr,
// out_status and out_copy_granules for exactly one cycle, flagged by
// out_valid. The receiver cannot stall the block, so it must capture the
// result in that cycle.
// The header walk reads one header per cycle from the header memory. An
// allocation converts its size to granules, walks the headers and appends
// at the break when no header fits. A free reads the old header and then
// frees the block. A reallocation that keeps its block converts the size
// and reads the old header; one that moves adds the walk and a free step.
// The block goes idle after each result before it takes the next request.
// Reset sets the break pointer just past the reserved preface granule and
// the arena limit to 4096; the header memory is not cleared, since a header
// is only ever read after it has been written.
// The arena limit register may only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
  parameter int ARENA_GRANULES = ffa_pkg::DEF_ARENA_GRANULES,
  parameter int GRANULE_BYTES  = ffa_pkg::DEF_GRANULE_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           start,
  output logic                           busy,
  input  logic [ffa_pkg::FUNC_W-1:0]     in_func,
  input  logic [ffa_pkg::BYTES_W-1:0]    in_req_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]     in_block_addr,
  // Result channel.
  output logic                           out_valid,
  output logic [ffa_pkg::ADDR_W-1:0]     out_result_addr,
  output logic [ffa_pkg::STATUS_W-1:0]   out_status,
  output logic [ffa_pkg::ADDR_W-1:0]     out_copy_granules,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffa_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffa_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import ffa_pkg::*;

  logic [CFG_W-1:0]         arena_limit_r, arena_limit_nxt;
  logic [PADDR_W-3:0]       reg_idx;
  logic                     cfg_wr;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;

  // The register index is the word address; only the arena limit exists.
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_ARENA_LIMIT);
  assign prdata  = (reg_idx == REG_ARENA_LIMIT) ? PDATA_W'(arena_limit_r) : '0;

  always_comb begin
    arena_limit_nxt = arena_limit_r;
    if (cfg_wr) begin
      arena_limit_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_limit_r <= ARENA_LIMIT_RST;
    end else begin
      arena_limit_r <= arena_limit_nxt;
    end
  end

  // The controller sequences each request; the datapath owns all storage.
  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  ffa_dp #(
    .ARENA_GRANULES (ARENA_GRANULES),
    .GRANULE_BYTES  (GRANULE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_req_bytes  (in_req_bytes),
    .in_block_addr (in_block_addr),
    .arena_limit   (arena_limit_r),
    .cmd           (cmd),
    .sts           (sts),
    .result_addr   (out_result_addr),
    .status        (out_status),
    .copy_granules (out_copy_granules)
  );

  // A taken request always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Each request produces a single one-cycle result strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Only a successful moved reallocation reports granules to copy.
  a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_copy_granules != '0)) |-> (out_status == RS_OK))
    else $error("copy count reported with a failing status");

  // The status code is always one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == RS_OK || out_status == RS_NO_SPACE ||
                   out_status == RS_ZERO))
    else $error("undefined status code on result");

endmodule

`default_nettype wire
